@@ hw/rtl/sti_pkg.sv @@
// Shared types, codes and sizes for the sorted table insert/delete block.
package sti_pkg;

    // Table size and derived widths.
    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Fixed widths of the request and result fields.
    localparam int OP_W      = 2;
    localparam int DATA_W    = 32;
    localparam int INDEX_W   = 4;
    localparam int STATUS_W  = 2;
    localparam int COUNT_F_W = 5;
    localparam int POS_W     = 4;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic signed [DATA_W-1:0]  value;
        logic [INDEX_W-1:0]        index;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_F_W-1:0]      entry_count;
        logic signed [DATA_W-1:0]  read_value;
        logic [POS_W-1:0]          position;
    } res_t;

    // Command broadcast to every cell of the row.
    typedef struct packed {
        logic                      ins_en;
        logic                      del_en;
        logic signed [DATA_W-1:0]  value;
    } bcast_t;

    // Where a cell sits relative to the current fill level.
    typedef struct packed {
        logic live;        // slot holds a valid entry
        logic at_count;    // slot is the first free one
        logic right_live;  // next slot up holds a valid entry
    } cell_pos_t;

    // Compare flags a cell reports to its right neighbor and to the top.
    typedef struct packed {
        logic gt;        // live entry greater than the value
        logic eq;        // live entry equal to the value
        logic ins_here;  // value lands in this slot on insert
        logic del_here;  // first equal entry sits in this slot
    } cell_stat_t;

endpackage

@@ hw/rtl/sti_cell.sv @@
// One slot of the sorted table: holds an entry, compares it, and shifts.
module sti_cell (
    input  logic                              aclk,
    input  sti_pkg::bcast_t                   bc,
    input  sti_pkg::cell_pos_t                pos,
    input  logic signed [sti_pkg::DATA_W-1:0] left_entry,
    input  logic signed [sti_pkg::DATA_W-1:0] right_entry,
    input  sti_pkg::cell_stat_t               left_stat,
    output logic signed [sti_pkg::DATA_W-1:0] entry,
    output sti_pkg::cell_stat_t               stat
);

    logic signed [sti_pkg::DATA_W-1:0] entry_reg;
    logic signed [sti_pkg::DATA_W-1:0] entry_next;
    logic                              ge;

    always_comb begin
        stat.gt       = pos.live && (entry_reg > bc.value);
        stat.eq       = pos.live && (entry_reg == bc.value);
        ge            = pos.live && (entry_reg >= bc.value);
        stat.ins_here = !left_stat.gt && (stat.gt || pos.at_count);
        stat.del_here = stat.eq && !left_stat.eq;
    end

    // Insert: larger entries move up one slot, the first of them is replaced by the value.
    // Delete: every entry from the match upward takes its right neighbor's entry.
    always_comb begin
        entry_next = entry_reg;
        if (bc.ins_en) begin
            if (left_stat.gt) begin
                entry_next = left_entry;
            end else if (stat.ins_here) begin
                entry_next = bc.value;
            end
        end else if (bc.del_en) begin
            if (ge && pos.right_live) begin
                entry_next = right_entry;
            end
        end
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

@@ hw/rtl/sorted_table_insert_delete.sv @@
// Top level of the sorted table: a row of compare-and-shift cells plus result register.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid/s_ready    s_req (opcode, value, index)
//   m_       out        m_valid/m_ready    m_res (status, entry_count, read_value, position)
//
// Each request is handled at its accepting edge: all cells compare their entry with
// the value in parallel and shift in place, and the result is captured in the output
// register. A new request is taken at every edge at which the output register is empty
// or being drained, so the block sustains one request per cycle while m_ready is high.
// Reset clears the entry count and the output valid; the table contents need no clearing.
// A stalled result holds s_ready low until m_ready takes it.
module sorted_table_insert_delete (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  sti_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output sti_pkg::res_t m_res
);

    localparam int DEPTH = sti_pkg::DEPTH;

    // Fill level of the table.
    logic [sti_pkg::CNT_W-1:0] count_reg;
    logic [sti_pkg::CNT_W-1:0] count_next;

    // Output register.
    logic          m_valid_reg;
    logic          m_valid_next;
    sti_pkg::res_t m_res_reg;
    sti_pkg::res_t m_res_next;

    logic accept;
    logic is_insert;
    logic is_delete;
    logic is_read;
    logic full;
    logic found;

    sti_pkg::bcast_t                   bc;
    sti_pkg::cell_pos_t                cpos  [DEPTH];
    sti_pkg::cell_stat_t               cstat [DEPTH];
    logic signed [sti_pkg::DATA_W-1:0] centry[DEPTH];

    logic [sti_pkg::IDX_W-1:0]         ins_pos;
    logic [sti_pkg::IDX_W-1:0]         del_pos;
    logic signed [sti_pkg::DATA_W-1:0] rd_data;
    logic                              rd_ok;

    // The output register frees up in the same cycle that its result is taken.
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    assign is_insert = (s_req.opcode == sti_pkg::OP_INSERT);
    assign is_delete = (s_req.opcode == sti_pkg::OP_DELETE);
    assign is_read   = (s_req.opcode == sti_pkg::OP_READ);
    assign full      = (int'(count_reg) >= DEPTH);

    // Each cell learns where it sits relative to the fill level.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            cpos[i].live       = (int'(count_reg) > i);
            cpos[i].at_count   = (int'(count_reg) == i);
            cpos[i].right_live = (int'(count_reg) > i + 1);
        end
    end

    // A delete only proceeds when some live entry matches the value.
    always_comb begin
        found = 1'b0;
        for (int i = 0; i < DEPTH; i++) begin
            found = found | cstat[i].eq;
        end
    end

    assign bc.ins_en = accept && is_insert && !full;
    assign bc.del_en = accept && is_delete && found;
    assign bc.value  = s_req.value;

    // The row of cells. Cell 0 has no left neighbor and the top cell has no right one.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [sti_pkg::DATA_W-1:0] left_entry;
        logic signed [sti_pkg::DATA_W-1:0] right_entry;
        sti_pkg::cell_stat_t               left_stat;

        if (g == 0) begin : g_first
            assign left_entry = '0;
            assign left_stat  = '0;
        end else begin : g_mid
            assign left_entry = centry[g-1];
            assign left_stat  = cstat[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = centry[g+1];
        end

        sti_cell u_cell (
            .aclk        (aclk),
            .bc          (bc),
            .pos         (cpos[g]),
            .left_entry  (left_entry),
            .right_entry (right_entry),
            .left_stat   (left_stat),
            .entry       (centry[g]),
            .stat        (cstat[g])
        );
    end

    // When the table has room exactly one cell raises ins_here, and at most one cell
    // raises del_here, so the slot number is an OR of the indexes of the flagged cells.
    always_comb begin
        ins_pos = '0;
        del_pos = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cstat[i].ins_here) begin
                ins_pos = ins_pos | sti_pkg::IDX_W'(i);
            end
            if (cstat[i].del_here) begin
                del_pos = del_pos | sti_pkg::IDX_W'(i);
            end
        end
    end

    // Indexed read; only slots reachable by the index field can be selected.
    always_comb begin
        rd_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (int'(s_req.index) == i) begin
                rd_data = centry[i];
            end
        end
        rd_ok = (int'(s_req.index) < int'(count_reg)) && (int'(s_req.index) < DEPTH);
    end

    // Next fill level and the result of the request being accepted.
    always_comb begin
        count_next             = count_reg;
        m_res_next.status      = sti_pkg::ST_OK;
        m_res_next.read_value  = '0;
        m_res_next.position    = '0;
        if (bc.ins_en) begin
            count_next = count_reg + 1'b1;
        end else if (bc.del_en) begin
            count_next = count_reg - 1'b1;
        end

        priority if (is_insert) begin
            if (full) begin
                m_res_next.status = sti_pkg::ST_FULL;
            end else begin
                m_res_next.position = sti_pkg::POS_W'(ins_pos);
            end
        end else if (is_delete) begin
            if (!found) begin
                m_res_next.status = sti_pkg::ST_ABSENT;
            end else begin
                m_res_next.position = sti_pkg::POS_W'(del_pos);
            end
        end else if (is_read) begin
            if (rd_ok) begin
                m_res_next.read_value = rd_data;
            end else begin
                m_res_next.status = sti_pkg::ST_RANGE;
            end
        end else begin
            // Unknown opcode: nothing changes, only the count is reported.
            m_res_next.status = sti_pkg::ST_OK;
        end
        m_res_next.entry_count = sti_pkg::COUNT_F_W'(count_next);
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_res_reg <= m_res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_res   = m_res_reg;

    // The fill level never passes the table size.
    assert property (@(posedge aclk) disable iff (!aresetn)
        int'(count_reg) <= DEPTH)
        else $error("entry count exceeds table size");

    // An accepted insert into a table with room grows the count by one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_insert && !full) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow the count");

    // A delete of an absent value leaves the count alone.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_delete && !found) |=> (count_reg == $past(count_reg)))
        else $error("failed delete changed the count");

    // A nonzero read value only comes with a successful result.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_res.read_value != '0)) |-> (m_res.status == sti_pkg::ST_OK))
        else $error("read value returned with an error status");

endmodule
